@@ design/qam_soft_llr_demapper_core_macros.svh @@
// Assertion macros for the soft LLR demapper.
// Depends on nothing; the user module provides clk and arst_n.
`ifndef QAM_SOFT_LLR_DEMAPPER_CORE_MACROS_SVH
`define QAM_SOFT_LLR_DEMAPPER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define QSLD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);
`define QSLD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define QSLD_ASSERT_IMPL(lbl, ante, cons, msg)
`define QSLD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ design/qsld_pkg.sv @@
// Shared types, constants and threshold table of the soft LLR demapper.
// No dependencies.
`timescale 1ns / 1ps
package qsld_pkg;
	localparam int COORD_WIDTH = 16;
	localparam int LLR_WIDTH   = 8;
	localparam int FRAC_BITS   = COORD_WIDTH - 1;
	localparam int DW          = COORD_WIDTH + 1;
	localparam int THR_SH      = 30 - FRAC_BITS;
	localparam int SCALE_WIDTH = 20;
	localparam int CLIP_WIDTH  = 7;
	localparam int CFG_WIDTH   = SCALE_WIDTH;

	localparam logic [1:0] MODE_QPSK   = 2'd0;
	localparam logic [1:0] MODE_QAM16  = 2'd1;
	localparam logic [1:0] MODE_QAM64  = 2'd2;
	localparam logic [1:0] MODE_QAM256 = 2'd3;

	localparam logic [1:0] REG_MODE  = 2'd0;
	localparam logic [1:0] REG_SCALE = 2'd1;
	localparam logic [1:0] REG_CLIP  = 2'd2;

	typedef logic signed [DW-1:0] dval_t;
	typedef logic signed [LLR_WIDTH-1:0] llr_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] i_sample;
		logic signed [COORD_WIDTH-1:0] q_sample;
	} in_t;

	typedef struct packed {
		logic signed [LLR_WIDTH-1:0] llr_0;
		logic signed [LLR_WIDTH-1:0] llr_1;
		logic signed [LLR_WIDTH-1:0] llr_2;
		logic signed [LLR_WIDTH-1:0] llr_3;
		logic signed [LLR_WIDTH-1:0] llr_4;
		logic signed [LLR_WIDTH-1:0] llr_5;
		logic signed [LLR_WIDTH-1:0] llr_6;
		logic signed [LLR_WIDTH-1:0] llr_7;
		logic [3:0]                  bits_valid;
	} out_t;

	typedef struct packed {
		logic [1:0]             mode;
		logic [SCALE_WIDTH-1:0] scale;
		logic [CLIP_WIDTH-1:0]  clip;
	} cfg_t;

	// Fold thresholds k/sqrt(P) in Q.30, outermost level first, reduced to Q.FRAC_BITS.
	function automatic dval_t thr_at(input logic [1:0] mode, input int unsigned lvl);
		longint q;
		longint r;
		q = 0;
		case (mode)
			MODE_QAM16: begin
				if (lvl == 0) q = 64'sd679093957;
			end
			MODE_QAM64: begin
				if (lvl == 0) q = 64'sd662727842;
				else if (lvl == 1) q = 64'sd331363921;
			end
			MODE_QAM256: begin
				if (lvl == 0) q = 64'sd658817909;
				else if (lvl == 1) q = 64'sd329408954;
				else if (lvl == 2) q = 64'sd164704477;
			end
			default: q = 0;
		endcase
		r = (q + (64'sd1 <<< (THR_SH - 1))) >>> THR_SH;
		return r[DW-1:0];
	endfunction
endpackage

@@ design/qsld_fold.sv @@
// Axis fold pipeline: negated MSB term and three nested fold differences.
// Depends on qsld_pkg.
`timescale 1ns / 1ps
module qsld_fold import qsld_pkg::*; (
	input  logic                          clk,
	input  logic [1:0]                    mode,
	input  logic signed [COORD_WIDTH-1:0] x,
	output dval_t                         d_s2 [4]
);
	dval_t xe, a0, d1;
	dval_t d0_s1, d1_s1;
	dval_t a1, d2, a2, d3;

	always_comb begin
		xe = {x[COORD_WIDTH-1], x};
		a0 = xe[DW-1] ? -xe : xe;
		d1 = a0 - thr_at(mode, 0);
	end

	always_ff @(posedge clk) begin
		d0_s1 <= -xe;
		d1_s1 <= d1;
	end

	always_comb begin
		a1 = d1_s1[DW-1] ? -d1_s1 : d1_s1;
		d2 = a1 - thr_at(mode, 1);
		a2 = d2[DW-1] ? -d2 : d2;
		d3 = a2 - thr_at(mode, 2);
	end

	always_ff @(posedge clk) begin
		d_s2[0] <= d0_s1;
		d_s2[1] <= d1_s1;
		d_s2[2] <= d2;
		d_s2[3] <= d3;
	end
endmodule

@@ design/qsld_lane.sv @@
// One LLR lane: scale product register, then rounding, clipping and sign.
// Depends on qsld_pkg.
`timescale 1ns / 1ps
module qsld_lane import qsld_pkg::*; (
	input  logic  clk,
	input  cfg_t  cfg,
	input  dval_t d,
	output llr_t  llr
);
	localparam int PW = DW + SCALE_WIDTH + 1;
	localparam int SH = FRAC_BITS + 8;
	localparam logic [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (SH - 1);

	logic signed [PW-1:0] prod_s3;
	logic [PW-1:0]        mag, rnd, rsh;
	logic [LLR_WIDTH-2:0] m;
	logic                 neg;

	always_ff @(posedge clk) begin
		prod_s3 <= d * $signed({1'b0, cfg.scale});
	end

	always_comb begin
		neg = prod_s3[PW-1];
		mag = neg ? PW'(-prod_s3) : PW'(prod_s3);
		rnd = mag + HALF;
		rsh = rnd >> SH;
		if (rsh > {{(PW-CLIP_WIDTH){1'b0}}, cfg.clip})
			m = cfg.clip[LLR_WIDTH-2:0];
		else
			m = rsh[LLR_WIDTH-2:0];
		llr = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
	end
endmodule

@@ design/qam_soft_llr_demapper_core.sv @@
// Max-log soft demapper for Gray QPSK/16/64/256-QAM: fold stages, lanes, output.
// Depends on qsld_pkg, qsld_fold, qsld_lane and the macros header.
// An accepted item passes the fold registers, the lane product register and the output register.
// Throughput one item per cycle; busy stays low, the pipeline never stalls.
// Reset clears the valid bits and loads the registers: QPSK, scale 256, clip 127.
`timescale 1ns / 1ps
`include "qam_soft_llr_demapper_core_macros.svh"
module qam_soft_llr_demapper_core import qsld_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  in_t                  sample,
	output logic                 done,
	output out_t                 result,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_idx,
	input  logic [CFG_WIDTH-1:0] cfg_wdata
);
	localparam logic [CLIP_WIDTH-1:0] OUT_MAX = CLIP_WIDTH'((1 << (LLR_WIDTH - 1)) - 1);

	logic [1:0]             mode_q;
	logic [SCALE_WIDTH-1:0] scale_q;
	logic [CLIP_WIDTH-1:0]  clip_q;
	cfg_t                   cfg;
	logic                   vld_s1, vld_s2, vld_s3, vld_s4;
	dval_t                  di [4];
	dval_t                  dq [4];
	llr_t                   li [4];
	llr_t                   lq [4];
	llr_t                   lo [8];
	logic [2:0]             nb;
	out_t                   res_s4;
	llr_t                   llr_bound;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_QPSK;
			scale_q <= SCALE_WIDTH'(256);
			clip_q  <= CLIP_WIDTH'(127);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE:  mode_q  <= cfg_wdata[1:0];
				REG_SCALE: scale_q <= cfg_wdata[SCALE_WIDTH-1:0];
				REG_CLIP:  clip_q  <= cfg_wdata[CLIP_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.mode  = mode_q;
		cfg.scale = scale_q;
		cfg.clip  = (clip_q > OUT_MAX) ? OUT_MAX : clip_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	qsld_fold u_fold_i (.clk(clk), .mode(mode_q), .x(sample.i_sample), .d_s2(di));
	qsld_fold u_fold_q (.clk(clk), .mode(mode_q), .x(sample.q_sample), .d_s2(dq));

	for (genvar g = 0; g < 4; g++) begin : g_lane
		qsld_lane u_lane_i (.clk(clk), .cfg(cfg), .d(di[g]), .llr(li[g]));
		qsld_lane u_lane_q (.clk(clk), .cfg(cfg), .d(dq[g]), .llr(lq[g]));
	end

	// I bits first, Q bits right after them, unused slots zero.
	always_comb begin
		for (int k = 0; k < 8; k++) lo[k] = '0;
		unique case (mode_q)
			MODE_QPSK: begin
				lo[0] = li[0];
				lo[1] = lq[0];
			end
			MODE_QAM16: begin
				lo[0] = li[0]; lo[1] = li[1];
				lo[2] = lq[0]; lo[3] = lq[1];
			end
			MODE_QAM64: begin
				lo[0] = li[0]; lo[1] = li[1]; lo[2] = li[2];
				lo[3] = lq[0]; lo[4] = lq[1]; lo[5] = lq[2];
			end
			MODE_QAM256: begin
				for (int k = 0; k < 4; k++) begin
					lo[k]     = li[k];
					lo[k + 4] = lq[k];
				end
			end
			default: ;
		endcase
		nb = {1'b0, mode_q} + 3'd1;
	end

	always_ff @(posedge clk) begin
		res_s4.llr_0      <= lo[0];
		res_s4.llr_1      <= lo[1];
		res_s4.llr_2      <= lo[2];
		res_s4.llr_3      <= lo[3];
		res_s4.llr_4      <= lo[4];
		res_s4.llr_5      <= lo[5];
		res_s4.llr_6      <= lo[6];
		res_s4.llr_7      <= lo[7];
		res_s4.bits_valid <= {nb, 1'b0};
	end

	assign done   = vld_s4;
	assign result = res_s4;

	assign llr_bound = llr_t'(cfg.clip);

	`QSLD_ASSERT_IMPL(a_latency, start && !busy, ##4 done, "accepted item gave no result")
	`QSLD_ASSERT_NEXT(a_no_spurious, !vld_s3, !done, "result without an item")
	`QSLD_ASSERT_IMPL(a_unused_zero, done && (result.bits_valid != 4'd8), result.llr_7 == '0, "unused LLR not zero")
	`QSLD_ASSERT_IMPL(a_clip, done, (result.llr_0 <= llr_bound) && (result.llr_0 >= -llr_bound), "LLR beyond clip")
endmodule
